@@ rtl/unicycle_tracking_controller_defines.svh @@
// Assertion macros used by the checker file utc_checker.sv.
`ifndef UNICYCLE_TRACKING_CONTROLLER_DEFINES_SVH
`define UNICYCLE_TRACKING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define UTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utc assertion failed");

// Next-cycle implication, checked in and out of reset.
`define UTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("utc assertion failed");

`endif

@@ rtl/utc_pkg.sv @@
// Types, constants and fixed-point helpers of the unicycle tracking controller.
package utc_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [71:0] Q30_ONE   = 72'sd1073741824;
  localparam logic signed [71:0] INNER_LIM = 72'sd8589934591;
  localparam logic signed [71:0] CMD_LIM   = 72'sd2147483647;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_B     = 3'd0,
    REG_INV_OFFSET_B = 3'd1,
    REG_GAIN_X       = 3'd2,
    REG_GAIN_Y       = 3'd3,
    REG_SPEED_LIMIT  = 3'd4,
    REG_TURN_LIMIT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [16:0] offset_b;
    logic [31:0] inv_offset_b;
    logic [24:0] gain_x;
    logic [24:0] gain_y;
    logic [30:0] speed_limit;
    logic [30:0] turn_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_speed;
    logic signed [31:0] ref_turn_rate;
  } pose_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [32:0] x;
    logic signed [32:0] y;
    pose_t              pose;
  } cordic_res_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // round half up, then arithmetic shift; n is a constant at every call
  function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v, input int n);
    logic signed [71:0] h;
    h = 72'sd1 <<< (n - 1);
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [71:0] sat(input logic signed [71:0] v,
                                             input logic signed [71:0] lim);
    logic signed [71:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

@@ rtl/utc_in_if.sv @@
// Input channel: one pose and reference sample per item.
interface utc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [31:0] ref_speed;
  logic signed [31:0] ref_turn_rate;

  modport source (output valid, output pos_x, output pos_y, output heading, output ref_x,
                  output ref_y, output ref_speed, output ref_turn_rate, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading, input ref_x,
                input ref_y, input ref_speed, input ref_turn_rate, output ready);
endinterface

@@ rtl/utc_out_if.sv @@
// Output channel: one saturated velocity command per item.
interface utc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] linear_cmd;
  logic signed [31:0] angular_cmd;
  logic               linear_clipped;
  logic               angular_clipped;

  modport source (output valid, output linear_cmd, output angular_cmd,
                  output linear_clipped, output angular_clipped, input ready);
  modport sink (input valid, input linear_cmd, input angular_cmd,
                input linear_clipped, input angular_clipped, output ready);
endinterface

@@ rtl/utc_cordic.sv @@
// Pipelined rotation-mode CORDIC: an input register, then one micro-rotation per stage.
module utc_cordic #(
  parameter int STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           heading,
  input  utc_pkg::pose_t        pose,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utc_pkg::cordic_res_t  res
);
  import utc_pkg::*;

  logic signed [32:0] x [0:STAGES];
  logic signed [32:0] y [0:STAGES];
  logic signed [33:0] z [0:STAGES];
  logic [1:0]         q [0:STAGES];
  pose_t              p [0:STAGES];
  logic [STAGES:0]    vld;
  logic [STAGES+1:0]  en;

  // a stage loads when empty or when the one after it moves
  always_comb begin
    en[STAGES+1] = out_ready;
    for (int k = STAGES; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x[0] <= CORDIC_X0;
      y[0] <= 33'sd0;
      z[0] <= $signed({4'b0000, heading[13:0], 16'h0000});
      q[0] <= heading[15:14];
      p[0] <= pose;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic signed [33:0] atan_k;
    assign atan_k = $signed({4'b0000, atan_turn(k)});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en[k+1]) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        if (!z[k][33]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - atan_k;
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + atan_k;
        end
        q[k+1] <= q[k];
        p[k+1] <= p[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES];
  assign res       = '{quad: q[STAGES], x: x[STAGES], y: y[STAGES], pose: p[STAGES]};

endmodule

@@ rtl/utc_cmd.sv @@
// Command pipeline: linearizing feedback, output transform and saturation.
module utc_cmd #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utc_pkg::cordic_res_t res,
  input  utc_pkg::cfg_t        cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   linear_cmd,
  output logic signed [31:0]   angular_cmd,
  output logic                 linear_clipped,
  output logic                 angular_clipped
);
  import utc_pkg::*;

  logic [9:1]  vld;
  logic [10:1] en;

  always_comb begin
    en[10] = out_ready;
    for (int k = 9; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= 9; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // S1: clamp CORDIC outputs, quadrant map, position errors
  logic signed [71:0] xc, yc;
  logic signed [31:0] cq, sq;
  always_comb begin
    xc = sat({{39{res.x[32]}}, res.x}, Q30_ONE);
    yc = sat({{39{res.y[32]}}, res.y}, Q30_ONE);
    case (res.quad)
      2'd0:    begin cq = xc[31:0];    sq = yc[31:0];    end
      2'd1:    begin cq = -yc[31:0];   sq = xc[31:0];    end
      2'd2:    begin cq = -xc[31:0];   sq = -yc[31:0];   end
      default: begin cq = yc[31:0];    sq = -xc[31:0];   end
    endcase
  end

  logic signed [31:0] c1, s1, vd1, wd1;
  logic signed [32:0] ex1, ey1;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1  <= cq;
      s1  <= sq;
      vd1 <= res.pose.ref_speed;
      wd1 <= res.pose.ref_turn_rate;
      ex1 <= {res.pose.ref_x[31], res.pose.ref_x} - {res.pose.pos_x[31], res.pose.pos_x};
      ey1 <= {res.pose.ref_y[31], res.pose.ref_y} - {res.pose.pos_y[31], res.pose.pos_y};
    end
  end

  // S2: gain and offset products
  logic signed [31:0] c2, s2, vd2;
  logic signed [58:0] pkx2, pky2;
  logic signed [49:0] pbw2;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2   <= c1;
      s2   <= s1;
      vd2  <= vd1;
      pkx2 <= $signed({1'b0, cfg.gain_x}) * ex1;
      pky2 <= $signed({1'b0, cfg.gain_y}) * ey1;
      pbw2 <= $signed({1'b0, cfg.offset_b}) * wd1;
    end
  end

  // S3: round and clamp to the inner range
  logic signed [71:0] kx_c, ky_c, bw_c;
  assign kx_c = sat(rnd_shr(pkx2, FRAC_BITS), INNER_LIM);
  assign ky_c = sat(rnd_shr(pky2, FRAC_BITS), INNER_LIM);
  assign bw_c = sat(rnd_shr(pbw2, FRAC_BITS), INNER_LIM);

  logic signed [31:0] c3, s3, vd3;
  logic signed [33:0] kx3, ky3, bw3;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      c3  <= c2;
      s3  <= s2;
      vd3 <= vd2;
      kx3 <= kx_c[33:0];
      ky3 <= ky_c[33:0];
      bw3 <= bw_c[33:0];
    end
  end

  // S4: reference terms rotated by the heading
  logic signed [31:0] c4, s4;
  logic signed [33:0] kx4, ky4;
  logic signed [63:0] m1, m3;
  logic signed [65:0] m2, m4;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      c4  <= c3;
      s4  <= s3;
      kx4 <= kx3;
      ky4 <= ky3;
      m1  <= vd3 * c3;
      m2  <= bw3 * s3;
      m3  <= vd3 * s3;
      m4  <= bw3 * c3;
    end
  end

  // S5: u1, u2
  logic signed [71:0] u1_c, u2_c;
  assign u1_c = sat(rnd_shr(m1, 30) - rnd_shr(m2, 30) + kx4, INNER_LIM);
  assign u2_c = sat(rnd_shr(m3, 30) + rnd_shr(m4, 30) + ky4, INNER_LIM);

  logic signed [31:0] c5, s5;
  logic signed [33:0] u15, u25;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      c5  <= c4;
      s5  <= s4;
      u15 <= u1_c[33:0];
      u25 <= u2_c[33:0];
    end
  end

  // S6: back into the body frame
  logic signed [65:0] p1, p2, p3, p4;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      p1 <= u15 * c5;
      p2 <= u25 * s5;
      p3 <= u25 * c5;
      p4 <= u15 * s5;
    end
  end

  // S7: v and the turn term
  logic signed [71:0] v_s, d_c;
  assign v_s = rnd_shr(p1, 30) + rnd_shr(p2, 30);
  assign d_c = sat(rnd_shr(p3, 30) - rnd_shr(p4, 30), CMD_LIM);

  logic signed [35:0] v7;
  logic signed [31:0] d7;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      v7 <= v_s[35:0];
      d7 <= d_c[31:0];
    end
  end

  // S8: scale by 1/b
  logic signed [35:0] v8;
  logic signed [64:0] pw8;
  always_ff @(posedge clk) begin
    if (en[8]) begin
      v8  <= v7;
      pw8 <= d7 * $signed({1'b0, cfg.inv_offset_b});
    end
  end

  // S9: output register with saturation
  logic signed [71:0] w_s, v_x, lv, lw;
  assign w_s = rnd_shr(pw8, FRAC_BITS);
  assign v_x = {{36{v8[35]}}, v8};
  assign lv  = $signed({41'd0, cfg.speed_limit});
  assign lw  = $signed({41'd0, cfg.turn_limit});

  always_ff @(posedge clk) begin
    if (en[9]) begin
      if (v_x > lv) begin
        linear_cmd     <= lv[31:0];
        linear_clipped <= 1'b1;
      end else if (v_x < -lv) begin
        linear_cmd     <= -lv[31:0];
        linear_clipped <= 1'b1;
      end else begin
        linear_cmd     <= v_x[31:0];
        linear_clipped <= 1'b0;
      end
      if (w_s > lw) begin
        angular_cmd     <= lw[31:0];
        angular_clipped <= 1'b1;
      end else if (w_s < -lw) begin
        angular_cmd     <= -lw[31:0];
        angular_clipped <= 1'b1;
      end else begin
        angular_cmd     <= w_s[31:0];
        angular_clipped <= 1'b0;
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[9];

endmodule

@@ rtl/unicycle_tracking_controller.sv @@
// Top level of the unicycle tracking controller.
// Each input item (measured pose, reference point, reference speed and turn rate)
// yields one velocity command item: linear_cmd and angular_cmd in signed Q16.16,
// each clamped to its symmetric limit, with a flag when the clamp acted. The block
// is a single pipeline that takes a new item every clock while in_ch.ready is high.
// It holds CORDIC_STAGES + 10 register stages (CORDIC_STAGES + 1 for the sine and
// cosine unit, 9 for the multiply chain and output register), and out_ch.valid
// rises once an accepted item has passed through the sine and cosine unit and the
// multiply chain into the output register. Stages advance individually, so a
// stalled output only backs up as far as needed and bubbles
// are squeezed out; in_ch.ready drops only when every stage is full and the
// output is held. Registers are written through cfg_wen / cfg_idx / cfg_data
// and should be changed only while the pipeline is empty; writes to an index
// of 6 or above are dropped.
module unicycle_tracking_controller #(
  parameter int FRAC_BITS     = utc_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = utc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [utc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [utc_pkg::CFG_DATA_W-1:0]  cfg_data,
  utc_in_if.sink                          in_ch,
  utc_out_if.source                       out_ch
);
  import utc_pkg::*;

  cfg_t        cfg;
  pose_t       pose;
  cordic_res_t cres;
  logic        cres_valid;
  logic        cres_ready;

  // register file; reset values are the nominal tuning
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_b     <= 17'd3277;
      cfg.inv_offset_b <= 32'd1310720;
      cfg.gain_x       <= 25'd262144;
      cfg.gain_y       <= 25'd262144;
      cfg.speed_limit  <= 31'd393216;
      cfg.turn_limit   <= 31'd262144;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_idx))
        REG_OFFSET_B:     cfg.offset_b     <= cfg_data[16:0];
        REG_INV_OFFSET_B: cfg.inv_offset_b <= cfg_data;
        REG_GAIN_X:       cfg.gain_x       <= cfg_data[24:0];
        REG_GAIN_Y:       cfg.gain_y       <= cfg_data[24:0];
        REG_SPEED_LIMIT:  cfg.speed_limit  <= cfg_data[30:0];
        REG_TURN_LIMIT:   cfg.turn_limit   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // heading goes to the CORDIC; the rest of the item rides alongside
  assign pose = '{pos_x: in_ch.pos_x, pos_y: in_ch.pos_y, ref_x: in_ch.ref_x,
                  ref_y: in_ch.ref_y, ref_speed: in_ch.ref_speed,
                  ref_turn_rate: in_ch.ref_turn_rate};

  utc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .heading   (in_ch.heading),
    .pose      (pose),
    .out_valid (cres_valid),
    .out_ready (cres_ready),
    .res       (cres)
  );

  utc_cmd #(.FRAC_BITS(FRAC_BITS)) u_cmd (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (cres_valid),
    .in_ready        (cres_ready),
    .res             (cres),
    .cfg             (cfg),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .linear_cmd      (out_ch.linear_cmd),
    .angular_cmd     (out_ch.angular_cmd),
    .linear_clipped  (out_ch.linear_clipped),
    .angular_clipped (out_ch.angular_clipped)
  );

endmodule

@@ rtl/utc_checker.sv @@
// Port-level checks for the tracking controller, bound to the top level.
`include "unicycle_tracking_controller_defines.svh"

module utc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] linear_cmd,
  input logic signed [31:0] angular_cmd
);

  // reset empties the pipeline
  `UTC_ASSERT_NXT(a_rst_empty, rst, !out_valid)
  // input back-pressure only when the output is held
  `UTC_ASSERT_IMP(a_bp_cause, !in_ready, out_valid && !out_ready)
  // a held result stays
  `UTC_ASSERT_NXT(a_hold_valid, !rst && out_valid && !out_ready, rst || out_valid)
  `UTC_ASSERT_NXT(a_hold_data, !rst && out_valid && !out_ready,
                  rst || ($stable(linear_cmd) && $stable(angular_cmd)))

endmodule

bind unicycle_tracking_controller utc_checker u_utc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .linear_cmd  (out_ch.linear_cmd),
  .angular_cmd (out_ch.angular_cmd)
);
